// ----- rtl/mir_pkg.sv -----
package mir_pkg;

  localparam int WORD_W    = 32;
  localparam int REQ_W     = 2;
  localparam int LINE_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int ROUTE_W   = 3;

  localparam int NUM_SOURCES_DEF = 32;
  localparam int NUM_OUTPUTS_DEF = 5;
  localparam int NUM_REGS_DEF    = 8;

  localparam logic [REQ_W-1:0] REQ_LINE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  localparam int REG_PENDING = 0;
  localparam int REG_MASK    = 1;
  localparam int REG_ROUTE0  = 2;
  localparam int REG_ROUTE1  = 3;
  localparam int REG_ROUTE2  = 4;

  typedef struct packed {
    logic [WORD_W-1:0] pending;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] route0;
    logic [WORD_W-1:0] route1;
    logic [WORD_W-1:0] route2;
  } irq_state_t;

endpackage

// ----- rtl/mir_regfile.sv -----
module mir_regfile #(
  parameter int NUM_SOURCES = mir_pkg::NUM_SOURCES_DEF,
  parameter int NUM_REGS    = mir_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [mir_pkg::REQ_W-1:0]      req_type,
  input  logic [mir_pkg::LINE_W-1:0]     line_number,
  input  logic                           line_level,
  input  logic [mir_pkg::REG_IDX_W-1:0]  reg_index,
  input  logic [mir_pkg::WORD_W-1:0]     write_data,
  output logic [mir_pkg::WORD_W-1:0]     read_data,
  output mir_pkg::irq_state_t            state_nxt
);
  import mir_pkg::*;

  localparam int RegAW = $clog2(NUM_REGS);

  logic [WORD_W-1:0] regs_r   [NUM_REGS];
  logic [WORD_W-1:0] regs_nxt [NUM_REGS];
  logic              idx_ok;

  assign idx_ok = (int'(reg_index) < NUM_REGS);

  always_comb begin
    if ((req_type == REQ_READ) && idx_ok) begin
      read_data = regs_r[RegAW'(reg_index)];
    end else begin
      read_data = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_REGS; k++) begin
      regs_nxt[k] = regs_r[k];
      if (accept && (req_type == REQ_WRITE) && idx_ok && (int'(reg_index) == k) &&
          (k != REG_PENDING)) begin
        regs_nxt[k] = write_data;
      end
    end
    if (accept && (req_type == REQ_LINE) && (int'(line_number) < NUM_SOURCES)) begin
      regs_nxt[REG_PENDING][line_number] = line_level;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_REGS; k++) begin
      if (!rst_n) begin
        regs_r[k] <= '0;
      end else begin
        regs_r[k] <= regs_nxt[k];
      end
    end
  end

  assign state_nxt.pending = regs_nxt[REG_PENDING];
  assign state_nxt.mask    = regs_nxt[REG_MASK];
  assign state_nxt.route0  = regs_nxt[REG_ROUTE0];
  assign state_nxt.route1  = regs_nxt[REG_ROUTE1];
  assign state_nxt.route2  = regs_nxt[REG_ROUTE2];

  a_pending_write_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req_type == REQ_WRITE)) |=>
      (regs_r[REG_PENDING] == $past(regs_r[REG_PENDING])))
    else $error("pending word changed by a bus write");

  a_line_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req_type == REQ_LINE) && (int'(line_number) < NUM_SOURCES)) |=>
      (regs_r[REG_PENDING][$past(line_number)] == $past(line_level)))
    else $error("pending bit does not follow line level");

endmodule

// ----- rtl/mir_router.sv -----
module mir_router #(
  parameter int NUM_SOURCES = mir_pkg::NUM_SOURCES_DEF,
  parameter int NUM_OUTPUTS = mir_pkg::NUM_OUTPUTS_DEF
) (
  input  mir_pkg::irq_state_t     state,
  output logic [NUM_OUTPUTS-1:0]  irq_out
);
  import mir_pkg::*;

  localparam int LineIdxW = $clog2(NUM_OUTPUTS);

  logic [WORD_W-1:0] active;

  assign active = state.pending & state.mask;

  always_comb begin
    logic [ROUTE_W-1:0] sel;
    irq_out = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      sel = {state.route2[i], state.route1[i], state.route0[i]};
      if (int'(sel) > NUM_OUTPUTS - 1) begin
        sel = ROUTE_W'(NUM_OUTPUTS - 1);
      end
      if (active[i]) begin
        irq_out[sel[LineIdxW-1:0]] = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/masked_interrupt_router_top.sv -----
// Masked interrupt router with NUM_SOURCES level sources and NUM_OUTPUTS lines.
// Input channel (in_*): one beat is a source level change, a register read or a
// register write, chosen by in_req_type. Register words: pending (read only),
// mask, route0, route1, route2, then plain storage up to NUM_REGS.
// Result channel (out_*): one beat per input beat, in order, carrying the read
// word (zero unless a read) and the output line levels after the beat applied.
// Timing: out_valid rises in the cycle after input accept. Throughput: one beat
// per cycle unless out_stall holds a result; the register file update and the
// routing OR run in the accept cycle and land in the single output register.
// Receiver stall: the output register holds its beat; in_stall rises while a
// held beat is stalled, so at most one result waits.
// Reset (rst_n low, synchronous): all register words clear to zero, so every
// source is masked and the routed lines are low; the output register empties.
module masked_interrupt_router_top #(
  parameter int NUM_SOURCES = mir_pkg::NUM_SOURCES_DEF,
  parameter int NUM_OUTPUTS = mir_pkg::NUM_OUTPUTS_DEF,
  parameter int NUM_REGS    = mir_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mir_pkg::REQ_W-1:0]      in_req_type,
  input  logic [mir_pkg::LINE_W-1:0]     in_line_number,
  input  logic                           in_line_level,
  input  logic [mir_pkg::REG_IDX_W-1:0]  in_reg_index,
  input  logic [mir_pkg::WORD_W-1:0]     in_write_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mir_pkg::WORD_W-1:0]     out_read_data,
  output logic [NUM_OUTPUTS-1:0]         out_irq
);
  import mir_pkg::*;

  logic                   accept;
  logic [WORD_W-1:0]      read_data;
  irq_state_t             state_nxt;
  logic [NUM_OUTPUTS-1:0] routed_irq;

  logic                   out_valid_r;
  logic [WORD_W-1:0]      out_read_data_r;
  logic [NUM_OUTPUTS-1:0] out_irq_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  mir_regfile #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_REGS    (NUM_REGS)
  ) u_regfile (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .line_number (in_line_number),
    .line_level  (in_line_level),
    .reg_index   (in_reg_index),
    .write_data  (in_write_data),
    .read_data   (read_data),
    .state_nxt   (state_nxt)
  );

  mir_router #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_router (
    .state   (state_nxt),
    .irq_out (routed_irq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data_r <= read_data;
      out_irq_r       <= routed_irq;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq       = out_irq_r;

  a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat did not reach the output register");

  a_drop_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result beat dropped while stalled");

endmodule
